// ===== sv/frc_pkg.sv =====
// Shared constants and control types for the truncated floating-point remainder.
package frc_pkg;

   localparam int DATA_W        = 64;
   localparam int DEF_EXP_BITS  = 11;
   localparam int DEF_FRAC_BITS = 52;

   typedef struct packed {
      logic load;
      logic init;
      logic norm;
      logic div;
      logic renorm;
      logic denorm;
      logic pack;
      logic emit;
   } frc_cmd_type;

   typedef struct packed {
      logic special;
      logic norm_done;
      logic gt;
      logic zero;
      logic hidden;
      logic ex_low;
   } frc_status_type;

endpackage

// ===== sv/frc_ctrl.sv =====
// Sequencer for the remainder: steps the datapath through its phases.
module frc_ctrl
   import frc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           out_free,
   input  frc_status_type st,
   output frc_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_NORM   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_RENORM = 3'd4;
   localparam logic [2:0] S_DENORM = 3'd5;
   localparam logic [2:0] S_PACK   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = st.special ? S_DONE : S_NORM;
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            if (st.norm_done) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (st.zero) state_in = S_DONE;
            else if (!st.gt) state_in = S_RENORM;
         end
         S_RENORM: begin
            cmd.renorm = 1'b1;
            if (st.hidden) state_in = S_DENORM;
         end
         S_DENORM: begin
            cmd.denorm = 1'b1;
            if (!st.ex_low) state_in = S_PACK;
         end
         S_PACK: begin
            cmd.pack = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/frc_dp.sv =====
// Datapath: operand unpacking, shift-subtract loop, renormalisation and packing.
module frc_dp
   import frc_pkg::*;
#(
   parameter int EXP_BITS  = DEF_EXP_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic              clock,
   input  frc_cmd_type       cmd,
   input  logic [DATA_W-1:0] x_in,
   input  logic [DATA_W-1:0] y_in,
   output frc_status_type    st,
   output logic [DATA_W-1:0] res,
   output logic              inval
);

   localparam int TOTAL = 1 + EXP_BITS + FRAC_BITS;
   localparam int MW    = FRAC_BITS + 2;
   localparam int EW    = EXP_BITS + 2;
   localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - TOTAL);
   localparam logic [DATA_W-1:0] SIGN_BIT  = DATA_W'(1) << (TOTAL - 1);
   localparam logic [DATA_W-1:0] FRAC_MASK = (DATA_W'(1) << FRAC_BITS) - DATA_W'(1);
   localparam logic [EXP_BITS-1:0] EXP_MAX = '1;
   localparam logic [DATA_W-1:0] QNAN =
      (DATA_W'(EXP_MAX) << FRAC_BITS) | (DATA_W'(1) << (FRAC_BITS - 1));

   logic [DATA_W-1:0]    xb_ff, yb_ff, res_ff;
   logic                 inval_ff;
   logic [MW-1:0]        mx_ff, my_ff;
   logic signed [EW-1:0] ex_ff, ey_ff;

   logic [DATA_W-1:0]   sign, xmag, ymag;
   logic [EXP_BITS-1:0] xe, ye;
   logic                invalid, x_below;
   logic [MW-1:0]       diff, mxs;
   logic                ge;

   always_comb begin
      sign    = xb_ff & SIGN_BIT;
      xmag    = xb_ff & ~SIGN_BIT;
      ymag    = yb_ff & ~SIGN_BIT;
      xe      = xmag[FRAC_BITS +: EXP_BITS];
      ye      = ymag[FRAC_BITS +: EXP_BITS];
      invalid = (ymag == '0) || (ye == EXP_MAX && (ymag & FRAC_MASK) != '0)
                || (xe == EXP_MAX);
      x_below = (xmag <= ymag);
      ge      = (mx_ff >= my_ff);
      diff    = mx_ff - my_ff;
      mxs     = ge ? diff : mx_ff;
   end

   assign st.special   = invalid || x_below;
   assign st.norm_done = mx_ff[FRAC_BITS] && my_ff[FRAC_BITS];
   assign st.gt        = (ex_ff > ey_ff);
   assign st.zero      = ge && (diff == '0);
   assign st.hidden    = mx_ff[FRAC_BITS];
   assign st.ex_low    = (ex_ff < EW'(1));
   assign res          = res_ff;
   assign inval        = inval_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xb_ff    <= x_in & WORD_MASK;
         yb_ff    <= y_in & WORD_MASK;
         inval_ff <= 1'b0;
      end
      if (cmd.init) begin
         mx_ff <= MW'(xmag[FRAC_BITS-1:0]) | (MW'(xe != '0) << FRAC_BITS);
         my_ff <= MW'(ymag[FRAC_BITS-1:0]) | (MW'(ye != '0) << FRAC_BITS);
         ex_ff <= (xe != '0) ? EW'(xe) : EW'(1);
         ey_ff <= (ye != '0) ? EW'(ye) : EW'(1);
         if (invalid) begin
            res_ff   <= QNAN & WORD_MASK;
            inval_ff <= 1'b1;
         end else if (x_below) begin
            res_ff <= (xmag == ymag) ? sign : xb_ff;
         end
      end
      if (cmd.norm) begin
         // Subnormal operands are brought up one place at a time.
         if (!mx_ff[FRAC_BITS]) begin
            mx_ff <= mx_ff << 1;
            ex_ff <= ex_ff - EW'(1);
         end
         if (!my_ff[FRAC_BITS]) begin
            my_ff <= my_ff << 1;
            ey_ff <= ey_ff - EW'(1);
         end
      end
      if (cmd.div) begin
         if (ge && diff == '0) begin
            res_ff <= sign;
         end else if (ex_ff > ey_ff) begin
            mx_ff <= mxs << 1;
            ex_ff <= ex_ff - EW'(1);
         end else begin
            mx_ff <= mxs;
         end
      end
      if (cmd.renorm && !mx_ff[FRAC_BITS]) begin
         mx_ff <= mx_ff << 1;
         ex_ff <= ex_ff - EW'(1);
      end
      if (cmd.denorm && ex_ff < EW'(1)) begin
         mx_ff <= mx_ff >> 1;
         ex_ff <= ex_ff + EW'(1);
      end
      if (cmd.pack) begin
         // A cleared hidden bit means the value was denormalised.
         if (mx_ff[FRAC_BITS])
            res_ff <= ((DATA_W'(ex_ff[EXP_BITS-1:0]) << FRAC_BITS)
                       | DATA_W'(mx_ff[FRAC_BITS-1:0]) | sign) & WORD_MASK;
         else
            res_ff <= (DATA_W'(mx_ff) | sign) & WORD_MASK;
      end
   end

endmodule

// ===== sv/float_remainder_truncated.sv =====
// Top level of the truncated floating-point remainder (fmod) on raw bit patterns.
// Usage:
//   The request channel carries one beat per operation: req_tdata holds the
//   dividend x in bits [63:0] and the divisor y in bits [127:64]. The response
//   channel returns one beat: rsp_tdata is the remainder bit pattern and
//   rsp_tuser is the invalid flag (canonical quiet NaN returned).
//   Only the low 1+EXP_BITS+FRAC_BITS bits of each operand are used.
// Sequencing:
//   One operation at a time. Special operands go from the init step straight
//   to the response register. Otherwise the sequencer normalises subnormal
//   operands, runs one shift-subtract step per unit of exponent difference,
//   then renormalises and denormalises the remainder before packing it. The
//   single shift-subtract unit sets the run time.
// Reset clears the sequencer and the response valid; no operation is lost
// after that point since none is in flight.
// A stalled receiver holds the response; the finished result waits in the
// datapath and a new request is taken once it has moved to the response register.
module float_remainder_truncated
   import frc_pkg::*;
#(
   parameter int EXP_BITS  = DEF_EXP_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*DATA_W-1:0] req_tdata,  // dividend_bits [63:0], divisor_bits [127:64]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,  // remainder_bits [63:0]
   output logic                rsp_tuser   // invalid [0]
);

   frc_cmd_type       cmd;
   frc_status_type    st;
   logic [DATA_W-1:0] res;
   logic              inval;
   logic              out_free;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0] rsp_tdata_ff;
   logic              rsp_tuser_ff;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   frc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .st        (st),
      .cmd       (cmd)
   );

   frc_dp #(
      .EXP_BITS  (EXP_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock (clock),
      .cmd   (cmd),
      .x_in  (req_tdata[DATA_W-1:0]),
      .y_in  (req_tdata[2*DATA_W-1:DATA_W]),
      .st    (st),
      .res   (res),
      .inval (inval)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.emit) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else rsp_tvalid_ff <= rsp_tvalid_in;
      if (cmd.emit) begin
         rsp_tdata_ff <= res;
         rsp_tuser_ff <= inval;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== sv/frc_checker.sv =====
// Port-level checks for the remainder block, bound to the top level.
module frc_checker
   import frc_pkg::*;
#(
   parameter int EXP_BITS  = DEF_EXP_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [DATA_W-1:0]   rsp_tdata,
   input logic                rsp_tuser
);

   localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

   // A held beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // One operation in flight: no new request right after one is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // An invalid response is the canonical NaN.
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[FRAC_BITS +: EXP_BITS] == EXP_MAX && rsp_tdata[FRAC_BITS-1])
      else $error("invalid response is not a NaN");

   // Nothing is offered straight after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind float_remainder_truncated frc_checker #(
   .EXP_BITS  (EXP_BITS),
   .FRAC_BITS (FRAC_BITS)
) u_frc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
